### hdl/pps_pkg.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering package
// Shared types, codes and constants of the pure pursuit steering block.
// ----------------------------------------------------------------------------
package pps_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = ADDR_W + 1;
  localparam int CFG_IDX_W  = 2;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LA_MIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LA_MAX  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LA_GAIN = 2'd2;

  localparam logic [30:0] LA_MIN_RESET  = 31'd1966080;
  localparam logic [30:0] LA_MAX_RESET  = 31'd2621440;
  localparam logic [15:0] LA_GAIN_RESET = 16'd6144;

  localparam logic [2:0] STAT_INTERP   = 3'd0;
  localparam logic [2:0] STAT_NO_ROOT  = 3'd1;
  localparam logic [2:0] STAT_NO_RANGE = 3'd2;
  localparam logic [2:0] STAT_NO_CROSS = 3'd3;
  localparam logic [2:0] STAT_FEW      = 3'd4;

  localparam int CORDIC_STEPS = 21;
  localparam int IT_W         = 5;
  localparam logic signed [23:0] PI_Q20      = 24'sd3294199;
  localparam logic signed [23:0] TWO_PI_Q20  = 24'sd6588397;
  localparam logic signed [23:0] HALF_PI_Q20 = 24'sd1647099;
  localparam logic signed [30:0] GAIN_K_Q30  = 31'sd652032874;

  typedef struct packed {
    logic               op;
    logic               restart;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] speed;
    logic signed [15:0] yaw;
    logic        [15:0] wheelbase;
  } pps_in_t;

  typedef struct packed {
    logic signed [15:0] steer_angle;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic        [14:0] tgt_speed;
    logic        [9:0]  target_index;
    logic        [2:0]  status;
  } pps_out_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [15:0] speed;
  } point_t;

  typedef struct packed {
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [15:0] yaw;
    logic        [15:0] wb;
  } steer_req_t;

  function automatic logic [31:0] mag33(input logic signed [32:0] v);
    logic signed [32:0] a;
    a = v[32] ? -v : v;
    return a[31:0];
  endfunction

  function automatic logic signed [23:0] atan_q20(input logic [IT_W-1:0] i);
    logic signed [23:0] r;
    case (i)
      5'd0:    r = 24'sd823550;
      5'd1:    r = 24'sd486170;
      5'd2:    r = 24'sd256879;
      5'd3:    r = 24'sd130396;
      5'd4:    r = 24'sd65451;
      5'd5:    r = 24'sd32757;
      5'd6:    r = 24'sd16383;
      5'd7:    r = 24'sd8192;
      5'd8:    r = 24'sd4096;
      5'd9:    r = 24'sd2048;
      5'd10:   r = 24'sd1024;
      5'd11:   r = 24'sd512;
      5'd12:   r = 24'sd256;
      5'd13:   r = 24'sd128;
      5'd14:   r = 24'sd64;
      5'd15:   r = 24'sd32;
      5'd16:   r = 24'sd16;
      5'd17:   r = 24'sd8;
      5'd18:   r = 24'sd4;
      5'd19:   r = 24'sd2;
      5'd20:   r = 24'sd1;
      default: r = 24'sd0;
    endcase
    return r;
  endfunction

endpackage

### hdl/pure_pursuit_steering.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering
// Stores a trajectory and answers steering queries against it.
// ----------------------------------------------------------------------------
// A load beat stores one point while the store has room and gives no result.
// For a query the path memory is streamed twice at one point per cycle (nearest
// search, then the walk to the lookahead crossing), the crossing is found by
// bisection, and the shared CORDIC unit gives the angle after halving the
// curvature term until it fits. The block takes one item at a time; a new beat
// is accepted while a finished result still waits on the output register.
module pure_pursuit_steering import pps_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  pps_in_t              in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output pps_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_LA1, S_LA2, S_LA3, S_NEAR, S_WALK, S_SEG, S_BIS,
    S_TGT0, S_TGT1, S_NOX, S_STEER, S_OUT
  } state_t;

  state_t               state_r;
  logic [30:0]          la_min_r, la_max_r;
  logic [15:0]          la_gain_r;
  logic [CNT_W-1:0]     cnt_r, n_r;
  pps_in_t              q_r;
  logic signed [32:0]   prod_r;
  logic [30:0]          la_r;
  logic [61:0]          d2_r;

  logic                 iss_on_r;
  logic [ADDR_W-1:0]    iss_idx_r, iss_end_r;
  logic                 rd_v_r, rd_last_r, a_v_r, a_last_r, b_v_r, b_last_r;
  logic [ADDR_W-1:0]    rd_idx_r, a_idx_r, b_idx_r;
  point_t               a_pt_r, b_pt_r;
  logic [31:0]          a_dxm_r, a_dym_r;
  logic [63:0]          b_sqx_r, b_sqy_r;

  logic [64:0]          best_r, dcur_r;
  point_t               best_pt_r, prev_pt_r, seg_s_r, seg_e_r;
  logic [ADDR_W-1:0]    near_r, fidx_r;

  logic signed [32:0]   ax_r, ay_r, ddx_r, ddy_r;
  logic [16:0]          lo_r, hi_r, mid_r;
  logic [1:0]           ph_r;
  logic [3:0]           step_r;
  logic signed [50:0]   qx_r, qy_r;
  logic                 qout_r;
  logic [61:0]          sqmx_r, sqmy_r;
  logic signed [50:0]   numx_r, numy_r;
  logic signed [34:0]   spn_r;

  logic signed [33:0]   dx_r, dy_r;
  logic signed [15:0]   steer_r;
  logic [31:0]          tx_r, ty_r;
  logic [14:0]          tsp_r;
  logic [9:0]           tidx_r;
  logic [2:0]           stat_r;
  logic                 go_r;
  logic                 out_valid_r;
  pps_out_t             out_r;

  logic                 in_fire, walking, found_now, iss_fire, upd_near;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [CNT_W-1:0]     base;
  point_t               ram_q, wpt;
  logic [64:0]          d_sum, lim, best_new;
  logic [ADDR_W-1:0]    near_new;
  point_t               bpt_new;
  logic [30:0]          la_c0, la_c1;
  logic [16:0]          mid;
  logic signed [50:0]   axs, ays, qx_c, qy_c;
  logic signed [50:0]   mqx, mqy;
  logic [33:0]          mx, my;
  logic signed [17:0]   w0, w1;
  logic signed [33:0]   p0, p1;
  logic signed [50:0]   rx, ry;
  logic signed [34:0]   rsp;
  logic signed [18:0]   spr;
  logic [14:0]          sp_cl, last_cl;
  logic signed [33:0]   ndx, ndy;
  logic                 steer_done;
  logic signed [15:0]   steer_angle;
  steer_req_t           sreq;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    base      = in_data.restart ? '0 : cnt_r;
    ram_we    = in_fire && (in_data.op == OP_LOAD) && (base < CNT_W'(MAX_POINTS));
    ram_waddr = base[ADDR_W-1:0];
    wpt.x     = in_data.x;
    wpt.y     = in_data.y;
    wpt.speed = in_data.speed;
  end

  pps_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_POINTS)
  ) u_path (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wpt),
    .raddr (iss_idx_r),
    .rdata (ram_q)
  );

  always_comb begin
    walking   = (state_r == S_NEAR) || (state_r == S_WALK);
    d_sum     = {1'b0, b_sqx_r} + {1'b0, b_sqy_r};
    lim       = {3'b0, d2_r};
    found_now = (state_r == S_WALK) && b_v_r && (dcur_r < lim) && (lim < d_sum);
    iss_fire  = iss_on_r && walking && !found_now;
    upd_near  = b_v_r && ((b_idx_r == '0) || (d_sum < best_r));
    near_new  = upd_near ? b_idx_r : near_r;
    best_new  = upd_near ? d_sum : best_r;
    bpt_new   = upd_near ? b_pt_r : best_pt_r;

    la_c0 = (!prod_r[32] && prod_r != '0) ? 31'(prod_r[31:4]) : '0;
    if (la_c0 < la_min_r) begin
      la_c0 = la_min_r;
    end
    la_c1 = (la_c0 > la_max_r) ? la_max_r : la_c0;

    mid  = 17'((18'(lo_r) + 18'(hi_r)) >> 1);
    axs  = {{2{ax_r[32]}}, ax_r, 16'h0};
    ays  = {{2{ay_r[32]}}, ay_r, 16'h0};
    qx_c = axs + $signed({1'b0, mid}) * ddx_r;
    qy_c = ays + $signed({1'b0, mid}) * ddy_r;
    mqx  = qx_r[50] ? -qx_r : qx_r;
    mqy  = qy_r[50] ? -qy_r : qy_r;
    mx   = mqx[49:16];
    my   = mqy[49:16];

    w1  = $signed({1'b0, lo_r});
    w0  = $signed({1'b0, 17'h10000 - lo_r});
    p0  = seg_s_r.speed * w0;
    p1  = seg_e_r.speed * w1;
    rx  = numx_r + 51'sd32768;
    ry  = numy_r + 51'sd32768;
    rsp = spn_r + 35'sd32768;
    spr = rsp[34:16];
    if (spr < 0) begin
      sp_cl = '0;
    end else if (spr > 19'sd32767) begin
      sp_cl = 15'h7FFF;
    end else begin
      sp_cl = spr[14:0];
    end
    last_cl = seg_e_r.speed[15] ? '0 : seg_e_r.speed[14:0];
    ndx = 34'($signed({seg_e_r.x[31], seg_e_r.x}) - $signed({q_r.x[31], q_r.x}));
    ndy = 34'($signed({seg_e_r.y[31], seg_e_r.y}) - $signed({q_r.y[31], q_r.y}));

    sreq.dx  = dx_r;
    sreq.dy  = dy_r;
    sreq.yaw = q_r.yaw;
    sreq.wb  = q_r.wheelbase;
  end

  pps_steer u_steer (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .req   (sreq),
    .done  (steer_done),
    .angle (steer_angle)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      la_min_r    <= LA_MIN_RESET;
      la_max_r    <= LA_MAX_RESET;
      la_gain_r   <= LA_GAIN_RESET;
      cnt_r       <= '0;
      iss_on_r    <= 1'b0;
      rd_v_r      <= 1'b0;
      a_v_r       <= 1'b0;
      b_v_r       <= 1'b0;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LA_MIN:  la_min_r  <= cfg_data[30:0];
          CFG_LA_MAX:  la_max_r  <= cfg_data[30:0];
          CFG_LA_GAIN: la_gain_r <= cfg_data[15:0];
          default: ;
        endcase
      end

      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      go_r     <= 1'b0;
      rd_v_r   <= iss_fire;
      rd_idx_r <= iss_idx_r;
      rd_last_r <= (iss_idx_r == iss_end_r);
      a_v_r    <= rd_v_r && walking && !found_now;
      a_idx_r  <= rd_idx_r;
      a_last_r <= rd_last_r;
      a_pt_r   <= ram_q;
      a_dxm_r  <= mag33($signed({ram_q.x[31], ram_q.x}) - $signed({q_r.x[31], q_r.x}));
      a_dym_r  <= mag33($signed({ram_q.y[31], ram_q.y}) - $signed({q_r.y[31], q_r.y}));
      b_v_r    <= a_v_r && walking && !found_now;
      b_idx_r  <= a_idx_r;
      b_last_r <= a_last_r;
      b_pt_r   <= a_pt_r;
      b_sqx_r  <= a_dxm_r * a_dxm_r;
      b_sqy_r  <= a_dym_r * a_dym_r;
      if (iss_fire) begin
        iss_idx_r <= iss_idx_r + 1'b1;
        if (iss_idx_r == iss_end_r) begin
          iss_on_r <= 1'b0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (in_data.op == OP_LOAD) begin
              cnt_r <= ram_we ? base + 1'b1 : base;
            end else begin
              q_r <= in_data;
              n_r <= cnt_r;
              if (cnt_r < CNT_W'(2)) begin
                steer_r <= '0;
                tx_r    <= '0;
                ty_r    <= '0;
                tsp_r   <= '0;
                tidx_r  <= '0;
                stat_r  <= STAT_FEW;
                state_r <= S_OUT;
              end else begin
                state_r <= S_LA1;
              end
            end
          end
        end
        S_LA1: begin
          prod_r  <= $signed({1'b0, la_gain_r}) * q_r.speed;
          state_r <= S_LA2;
        end
        S_LA2: begin
          la_r    <= la_c1;
          state_r <= S_LA3;
        end
        S_LA3: begin
          d2_r      <= la_r * la_r;
          iss_idx_r <= '0;
          iss_end_r <= ADDR_W'(n_r - CNT_W'(2));
          iss_on_r  <= 1'b1;
          state_r   <= S_NEAR;
        end
        S_NEAR: begin
          best_r    <= best_new;
          near_r    <= near_new;
          best_pt_r <= bpt_new;
          if (b_v_r && b_last_r) begin
            iss_idx_r <= near_new + 1'b1;
            iss_end_r <= ADDR_W'(n_r - CNT_W'(1));
            iss_on_r  <= 1'b1;
            dcur_r    <= best_new;
            prev_pt_r <= bpt_new;
            state_r   <= S_WALK;
          end
        end
        S_WALK: begin
          if (found_now) begin
            iss_on_r <= 1'b0;
            seg_s_r  <= prev_pt_r;
            seg_e_r  <= b_pt_r;
            fidx_r   <= b_idx_r;
            state_r  <= S_SEG;
          end else if (b_v_r) begin
            dcur_r    <= d_sum;
            prev_pt_r <= b_pt_r;
            if (b_last_r) begin
              seg_e_r <= b_pt_r;
              state_r <= S_NOX;
            end
          end
        end
        S_SEG: begin
          ax_r    <= $signed({seg_s_r.x[31], seg_s_r.x}) - $signed({q_r.x[31], q_r.x});
          ay_r    <= $signed({seg_s_r.y[31], seg_s_r.y}) - $signed({q_r.y[31], q_r.y});
          ddx_r   <= $signed({seg_e_r.x[31], seg_e_r.x}) - $signed({seg_s_r.x[31], seg_s_r.x});
          ddy_r   <= $signed({seg_e_r.y[31], seg_e_r.y}) - $signed({seg_s_r.y[31], seg_s_r.y});
          lo_r    <= '0;
          hi_r    <= 17'h10000;
          ph_r    <= '0;
          step_r  <= '0;
          state_r <= S_BIS;
        end
        S_BIS: begin
          unique case (ph_r)
            2'd0: begin
              mid_r <= mid;
              qx_r  <= qx_c;
              qy_r  <= qy_c;
              ph_r  <= 2'd1;
            end
            2'd1: begin
              qout_r <= (mx[33:31] != '0) || (my[33:31] != '0);
              sqmx_r <= mx[30:0] * mx[30:0];
              sqmy_r <= my[30:0] * my[30:0];
              ph_r   <= 2'd2;
            end
            default: begin
              if (!qout_r && ({1'b0, sqmx_r} + {1'b0, sqmy_r} < {1'b0, d2_r})) begin
                lo_r <= mid_r;
              end else begin
                hi_r <= mid_r;
              end
              ph_r   <= 2'd0;
              step_r <= step_r + 1'b1;
              if (step_r == 4'd15) begin
                state_r <= S_TGT0;
              end
            end
          endcase
        end
        S_TGT0: begin
          numx_r  <= axs + w1 * ddx_r;
          numy_r  <= ays + w1 * ddy_r;
          spn_r   <= 35'(p0) + 35'(p1);
          state_r <= S_TGT1;
        end
        S_TGT1: begin
          dx_r    <= rx[49:16];
          dy_r    <= ry[49:16];
          tx_r    <= q_r.x + rx[47:16];
          ty_r    <= q_r.y + ry[47:16];
          tsp_r   <= sp_cl;
          tidx_r  <= 10'(fidx_r);
          stat_r  <= STAT_INTERP;
          go_r    <= 1'b1;
          state_r <= S_STEER;
        end
        S_NOX: begin
          dx_r    <= ndx;
          dy_r    <= ndy;
          tx_r    <= seg_e_r.x;
          ty_r    <= seg_e_r.y;
          tsp_r   <= last_cl;
          tidx_r  <= 10'(near_r);
          stat_r  <= STAT_NO_CROSS;
          go_r    <= 1'b1;
          state_r <= S_STEER;
        end
        S_STEER: begin
          if (steer_done) begin
            steer_r <= steer_angle;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_r.steer_angle  <= steer_r;
            out_r.target_x     <= tx_r;
            out_r.target_y     <= ty_r;
            out_r.tgt_speed    <= tsp_r;
            out_r.target_index <= tidx_r;
            out_r.status       <= stat_r;
            out_valid_r        <= 1'b1;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/pps_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/pps_steer.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering angle unit
// Rotates the target offset into the vehicle frame and takes the arctangent
// of the curvature term with one shared CORDIC datapath.
// ----------------------------------------------------------------------------
module pps_steer import pps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  steer_req_t         req,
  output logic               done,
  output logic signed [15:0] angle
);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_SQ, S_ROT, S_YK, S_NM, S_NSH, S_NORM, S_VEC, S_FIN
  } state_t;

  localparam logic signed [56:0] LIM30 = 57'sd1073741824;

  state_t                 state_r;
  steer_req_t             req_r;
  logic [2:0]             s_r;
  logic signed [30:0]     dxs_r, dys_r;
  logic signed [33:0]     vx_r, vy_r;
  logic signed [23:0]     vz_r;
  logic [IT_W-1:0]        it_r;
  logic signed [61:0]     sqx_r, sqy_r;
  logic signed [64:0]     prodk_r;
  logic signed [50:0]     nm_r;
  logic [61:0]            nx_r;
  logic signed [56:0]     ny_r;
  logic                   done_r;
  logic signed [15:0]     angle_r;

  logic [33:0]            magx, magy;
  logic [2:0]             sh;
  logic signed [33:0]     shx, shy;
  logic signed [23:0]     z0, zw, zn;
  logic signed [33:0]     xs, ys;
  logic signed [23:0]     at;
  logic signed [33:0]     yc;
  logic signed [56:0]     nval;
  logic signed [23:0]     zr;

  always_comb begin
    magx = req_r.dx[33] ? 34'(-req_r.dx) : 34'(req_r.dx);
    magy = req_r.dy[33] ? 34'(-req_r.dy) : 34'(req_r.dy);
    sh   = 3'd4;
    for (int k = 4; k >= 0; k--) begin
      if ((magx >> k) < 34'd1073741824 && (magy >> k) < 34'd1073741824) begin
        sh = 3'(k);
      end
    end
    shx  = req_r.dx >>> sh;
    shy  = req_r.dy >>> sh;
    z0   = {{1{req_r.yaw[15]}}, req_r.yaw, 7'h0};
    if (z0 > PI_Q20) begin
      zw = z0 - TWO_PI_Q20;
    end else if (z0 < -PI_Q20) begin
      zw = z0 + TWO_PI_Q20;
    end else begin
      zw = z0;
    end
    zn   = -zw;
    xs   = vx_r >>> it_r;
    ys   = vy_r >>> it_r;
    at   = atan_q20(it_r);
    yc   = prodk_r[63:30];
    nval = {{6{nm_r[50]}}, nm_r} <<< (3'd5 - s_r);
    zr   = vz_r + 24'sd32;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            req_r   <= req;
            state_r <= S_PREP;
          end
        end
        S_PREP: begin
          s_r   <= sh;
          dxs_r <= shx[30:0];
          dys_r <= shy[30:0];
          if (zn > HALF_PI_Q20) begin
            vx_r <= -shy;
            vy_r <= shx;
            vz_r <= zn - HALF_PI_Q20;
          end else if (zn < -HALF_PI_Q20) begin
            vx_r <= shy;
            vy_r <= -shx;
            vz_r <= zn + HALF_PI_Q20;
          end else begin
            vx_r <= shx;
            vy_r <= shy;
            vz_r <= zn;
          end
          it_r    <= '0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          sqx_r   <= dxs_r * dxs_r;
          sqy_r   <= dys_r * dys_r;
          state_r <= S_ROT;
        end
        S_ROT: begin
          if (vz_r >= 0) begin
            vx_r <= vx_r - ys;
            vy_r <= vy_r + xs;
            vz_r <= vz_r - at;
          end else begin
            vx_r <= vx_r + ys;
            vy_r <= vy_r - xs;
            vz_r <= vz_r + at;
          end
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(CORDIC_STEPS - 1)) begin
            state_r <= S_YK;
          end
        end
        S_YK: begin
          prodk_r <= vy_r * GAIN_K_Q30;
          state_r <= S_NM;
        end
        S_NM: begin
          nm_r    <= yc * $signed({1'b0, req_r.wb});
          state_r <= S_NSH;
        end
        S_NSH: begin
          if (nval == '0) begin
            vz_r    <= '0;
            state_r <= S_FIN;
          end else begin
            nx_r    <= 62'(sqx_r) + 62'(sqy_r);
            ny_r    <= nval;
            state_r <= S_NORM;
          end
        end
        S_NORM: begin
          if (nx_r >= 62'd1073741824 || ny_r >= LIM30 || ny_r <= -LIM30) begin
            nx_r <= nx_r >> 1;
            ny_r <= ny_r >>> 1;
          end else begin
            vx_r    <= $signed({1'b0, nx_r[32:0]});
            vy_r    <= ny_r[33:0];
            vz_r    <= '0;
            it_r    <= '0;
            state_r <= S_VEC;
          end
        end
        S_VEC: begin
          if (vy_r >= 0) begin
            vx_r <= vx_r + ys;
            vy_r <= vy_r - xs;
            vz_r <= vz_r + at;
          end else begin
            vx_r <= vx_r - ys;
            vy_r <= vy_r + xs;
            vz_r <= vz_r - at;
          end
          it_r <= it_r + 1'b1;
          if (it_r == IT_W'(CORDIC_STEPS - 1)) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          angle_r <= zr[21:6];
          done_r  <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = done_r;
  assign angle = angle_r;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Pure pursuit steering testbench
// Loads trajectories and sends steering queries through the valid/ready input,
// predicts every query result with a bit-true model of the block and checks
// each output beat against it, across several lookahead settings and patterns
// of sender and receiver idling.
// ----------------------------------------------------------------------------
module testbench;
  import pps_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int       WATCHDOG_LIMIT = 20000;
  localparam longint   LIM30          = 64'sd1073741824;
  localparam longint   ONE_M          = 64'sd65536;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  pps_in_t              in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  pps_out_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_LA_MIN;
  logic [31:0]          cfg_data  = '0;

  pps_in_t  pending_beats[$];
  pps_out_t expected_steer[$];
  int       in_idle_pct  = 0;
  int       out_idle_pct = 0;
  int       rx_hold      = 0;
  int       errors       = 0;
  int       quiet_cycles = 0;
  logic     in_hs;

  longint path_x[MAX_POINTS];
  longint path_y[MAX_POINTS];
  longint path_spd[MAX_POINTS];
  int     path_len = 0;
  longint la_min   = LA_MIN_RESET;
  longint la_max   = LA_MAX_RESET;
  longint la_gain  = LA_GAIN_RESET;

  longint arctab[CORDIC_STEPS] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
                                   8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8,
                                   4, 2, 1};

  pure_pursuit_steering u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic longint unsigned mag64(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m;
  endfunction

  function automatic logic [64:0] dist_sq(longint dx, longint dy);
    logic [64:0] ax;
    logic [64:0] ay;
    ax = mag64(dx);
    ay = mag64(dy);
    return ax * ax + ay * ay;
  endfunction

  function automatic bit inside_circle(longint qx, longint qy, longint unsigned d2);
    longint unsigned mx;
    longint unsigned my;
    mx = mag64(qx) >> 16;
    my = mag64(qy) >> 16;
    if (mx >= 64'h8000_0000 || my >= 64'h8000_0000) return 1'b0;
    return (mx * mx + my * my) < d2;
  endfunction

  function automatic logic [15:0] steer_calc(longint dx, longint dy, longint yaw, longint wb);
    int     s;
    longint x, y, z, t, yc, nn, xs, ys, r;
    s = 0;
    while ((mag64(dx) >> s) >= 64'd1073741824 || (mag64(dy) >> s) >= 64'd1073741824) s++;
    dx = dx >>> s;
    dy = dy >>> s;
    r = dx * dx + dy * dy;
    z = yaw * 128;
    if (z > longint'(PI_Q20)) z -= longint'(TWO_PI_Q20);
    if (z < -longint'(PI_Q20)) z += longint'(TWO_PI_Q20);
    z = -z;
    x = dx;
    y = dy;
    if (z > longint'(HALF_PI_Q20)) begin
      t = x; x = -y; y = t; z -= longint'(HALF_PI_Q20);
    end else if (z < -longint'(HALF_PI_Q20)) begin
      t = x; x = y; y = -t; z += longint'(HALF_PI_Q20);
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctab[i];
      end else begin
        x += ys; y -= xs; z += arctab[i];
      end
    end
    yc = (y * longint'(GAIN_K_Q30)) >>> 30;
    nn = yc * wb * longint'(32 >> s);
    if (nn == 0) return 16'd0;
    x = r;
    y = nn;
    while (x >= LIM30 || y >= LIM30 || y <= -LIM30) begin
      x = x >>> 1;
      y = y >>> 1;
    end
    z = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += arctab[i];
      end else begin
        x -= ys; y += xs; z -= arctab[i];
      end
    end
    t = (z + 32) >>> 6;
    return t[15:0];
  endfunction

  function automatic longint clamp_spd(longint v);
    if (v < 0) return 0;
    if (v > 32767) return 32767;
    return v;
  endfunction

  function automatic pps_out_t steer_query(pps_in_t it);
    pps_out_t        r;
    longint          vx, vy, prod, la, tx, ty, tsp, ax, ay, ddx, ddy, lo, hi, mid;
    longint unsigned d2;
    logic [64:0]     best, dcur, dlast, d;
    int              nearest, seg;
    bit              found;
    r = '0;
    if (path_len < 2) begin
      r.status = STAT_FEW;
      return r;
    end
    vx = it.x;
    vy = it.y;
    best = dist_sq(path_x[0] - vx, path_y[0] - vy);
    nearest = 0;
    for (int i = 1; i + 1 < path_len; i++) begin
      d = dist_sq(path_x[i] - vx, path_y[i] - vy);
      if (d < best) begin
        best = d;
        nearest = i;
      end
    end
    prod = la_gain * longint'(it.speed);
    la = (prod > 0) ? (prod >>> 4) : 0;
    if (la < la_min) la = la_min;
    if (la > la_max) la = la_max;
    d2 = la * la;
    dcur = best;
    found = 1'b0;
    seg = 0;
    for (int i = nearest + 1; i < path_len && !found; i++) begin
      dlast = dcur;
      dcur = dist_sq(path_x[i] - vx, path_y[i] - vy);
      if (dlast < {1'b0, d2} && {1'b0, d2} < dcur) begin
        found = 1'b1;
        seg = i;
      end
    end
    if (found) begin
      ax = path_x[seg-1] - vx;
      ay = path_y[seg-1] - vy;
      ddx = path_x[seg] - path_x[seg-1];
      ddy = path_y[seg] - path_y[seg-1];
      lo = 0;
      hi = 65536;
      for (int k = 0; k < 16; k++) begin
        mid = (lo + hi) >>> 1;
        if (inside_circle(ax * 65536 + mid * ddx, ay * 65536 + mid * ddy, d2)) lo = mid;
        else hi = mid;
      end
      tx = vx + ((ax * 65536 + lo * ddx + 32768) >>> 16);
      ty = vy + ((ay * 65536 + lo * ddy + 32768) >>> 16);
      tsp = clamp_spd((path_spd[seg-1] * (65536 - lo) + path_spd[seg] * lo + 32768) >>> 16);
      r.target_index = seg[9:0];
      r.status = STAT_INTERP;
    end else begin
      tx = path_x[path_len-1];
      ty = path_y[path_len-1];
      tsp = clamp_spd(path_spd[path_len-1]);
      r.target_index = nearest[9:0];
      r.status = STAT_NO_CROSS;
    end
    r.steer_angle = steer_calc(tx - vx, ty - vy, it.yaw, it.wheelbase);
    r.target_x = tx[31:0];
    r.target_y = ty[31:0];
    r.tgt_speed = tsp[14:0];
    return r;
  endfunction

  // Input side: the model is advanced on every accepted beat.
  always @(posedge clk) begin
    in_hs = rst_n && in_valid && in_ready;
    if (in_hs) begin
      if (in_data.op == OP_LOAD) begin
        if (in_data.restart) path_len = 0;
        if (path_len < MAX_POINTS) begin
          path_x[path_len] = in_data.x;
          path_y[path_len] = in_data.y;
          path_spd[path_len] = in_data.speed;
          path_len++;
        end
      end else begin
        expected_steer = {expected_steer, steer_query(in_data)};
      end
    end
  end

  always @(negedge clk) begin
    logic nv;
    nv = in_valid && !in_hs;
    if (!nv && rst_n && pending_beats.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
      in_data <= pending_beats.pop_front();
      nv = 1'b1;
    end
    in_valid <= nv;
  end

  always @(negedge clk) begin
    if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    pps_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_steer.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat %p", out_data);
      end else begin
        e = expected_steer.pop_front();
        if (out_data.steer_angle !== e.steer_angle || out_data.target_x !== e.target_x ||
            out_data.target_y !== e.target_y || out_data.tgt_speed !== e.tgt_speed ||
            out_data.target_index !== e.target_index || out_data.status !== e.status) begin
          errors++;
          if (errors <= 10) begin
            $display("mismatch: steer %0d/%0d tx %h/%h ty %h/%h spd %0d/%0d idx %0d/%0d st %0d/%0d",
                     out_data.steer_angle, e.steer_angle, out_data.target_x, e.target_x,
                     out_data.target_y, e.target_y, out_data.tgt_speed, e.tgt_speed,
                     out_data.target_index, e.target_index, out_data.status, e.status);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic add_load(bit restart, longint x, longint y, longint spd);
    pps_in_t b;
    b = '0;
    b.op = OP_LOAD;
    b.restart = restart;
    b.x = x[31:0];
    b.y = y[31:0];
    b.speed = spd[15:0];
    pending_beats = {pending_beats, b};
  endtask

  task automatic add_query(longint x, longint y, longint spd, longint yaw, longint wb,
                           bit restart = 1'b0);
    pps_in_t b;
    b.op = OP_QUERY;
    b.restart = restart;
    b.x = x[31:0];
    b.y = y[31:0];
    b.speed = spd[15:0];
    b.yaw = yaw[15:0];
    b.wheelbase = wb[15:0];
    pending_beats = {pending_beats, b};
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LA_MIN:  la_min = val[30:0];
      CFG_LA_MAX:  la_max = val[30:0];
      CFG_LA_GAIN: la_gain = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_beats.size() > 0 || in_valid || expected_steer.size() > 0);
    repeat (20) @(posedge clk);
  endtask

  // A path of roughly evenly spaced points, then queries from near the path.
  task automatic add_path_run(output int added);
    int     n, nq, k;
    longint x0, y0, sx, sy;
    n = $urandom_range(2, 12);
    x0 = $signed($urandom_range(0, 2000)) - 1000;
    y0 = $signed($urandom_range(0, 2000)) - 1000;
    sx = $signed($urandom_range(0, 30 * 65536)) - 15 * 65536;
    sy = $signed($urandom_range(0, 30 * 65536)) - 15 * 65536;
    for (int i = 0; i < n; i++)
      add_load(i == 0, x0 * ONE_M + i * sx + $signed($urandom_range(0, 131072)) - 65536,
               y0 * ONE_M + i * sy + $signed($urandom_range(0, 131072)) - 65536,
               $signed($urandom_range(0, 12000)) - 2000);
    nq = $urandom_range(1, 4);
    for (int q = 0; q < nq; q++) begin
      k = $urandom_range(0, n - 1);
      add_query(x0 * ONE_M + k * sx + $signed($urandom_range(0, 10 * 65536)) - 5 * 65536,
                y0 * ONE_M + k * sy + $signed($urandom_range(0, 10 * 65536)) - 5 * 65536,
                $signed($urandom_range(0, 9000)) - 1000, $signed($urandom_range(0, 65535)) - 32768,
                $urandom_range(0, 65535));
    end
    added = n + nq;
  endtask

  task automatic add_noise();
    pps_in_t b;
    b.op = $urandom_range(1);
    b.restart = ($urandom_range(3) == 0);
    b.x = $urandom;
    b.y = $urandom;
    b.speed = $urandom;
    b.yaw = $urandom;
    b.wheelbase = $urandom;
    pending_beats = {pending_beats, b};
  endtask

  task automatic random_items(int count);
    int done, added;
    done = 0;
    while (done < count) begin
      if ($urandom_range(9) < 7) begin
        add_path_run(added);
        done += added;
      end else begin
        add_noise();
        done++;
      end
    end
  endtask

  initial begin
    int pct[4][2];
    pct = '{'{0, 0}, '{70, 0}, '{0, 70}, '{26, 26}};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty path with restart on a query, then a single point.
    add_query(0, 0, 0, 0, 4096, 1'b1);
    add_load(1'b1, 0, 0, 32767);
    add_query(0, 0, 0, 0, 4096);
    // Target on the vehicle, zero wheelbase and a speed clamped at zero.
    add_load(1'b0, 0, 0, -32768);
    add_query(0, 0, 100, 0, 0);
    // Straight path: interpolation at minimum, negative and maximum speeds.
    add_load(1'b1, 0, 0, 2560);
    add_load(1'b0, 20 * ONE_M, 0, 5120);
    add_load(1'b0, 40 * ONE_M, 0, -512);
    add_load(1'b0, 60 * ONE_M, 5 * ONE_M, 32767);
    add_query(0, 0, 0, 0, 10240);
    add_query(ONE_M, -2 * ONE_M, -32768, -32768, 65535);
    add_query(-ONE_M, ONE_M, 32767, 32767, 65535);
    add_query(0, 0, 1500, 12868, 1);
    // Far target at the corners of the coordinate range.
    add_load(1'b1, -64'sd2147483648, -64'sd2147483648, 32767);
    add_load(1'b0, 64'sd2147483647, 64'sd2147483647, -1);
    add_query(64'sd2147483647, -64'sd2147483648, 32767, -32768, 65535);
    add_query(-64'sd2147483648, 64'sd2147483647, 0, 32767, 4096);
    drain();

    // Fill the store past its depth and query the full path.
    for (int i = 0; i < MAX_POINTS + 6; i++)
      add_load(i == 0, i * 3 * ONE_M, (i % 7) * ONE_M, i * 8);
    add_query(10 * ONE_M, 0, 2000, 0, 8192);
    add_query(3000 * ONE_M, 2 * ONE_M, 5000, 4000, 8192);
    drain();

    for (int p = 0; p < 4; p++) begin
      in_idle_pct = pct[p][0];
      out_idle_pct = pct[p][1];
      case (p)
        0: begin
          write_reg(CFG_LA_MIN, LA_MIN_RESET);
          write_reg(CFG_LA_MAX, LA_MAX_RESET);
          write_reg(CFG_LA_GAIN, LA_GAIN_RESET);
        end
        1: begin
          write_reg(CFG_LA_MIN, 32'h0);
          write_reg(CFG_LA_MAX, 32'hFFFF_FFFF);
          write_reg(CFG_LA_GAIN, 32'hFFFF_FFFF);
        end
        2: begin
          write_reg(CFG_LA_MIN, 50 * 65536);
          write_reg(CFG_LA_MAX, 10 * 65536);
          write_reg(CFG_LA_GAIN, $urandom);
        end
        default: begin
          write_reg(CFG_LA_MIN, $urandom_range(2, 20) * 65536 + $urandom_range(0, 65535));
          write_reg(CFG_LA_MAX, $urandom_range(20, 60) * 65536 | (32'h1 << 31));
          write_reg(CFG_LA_GAIN, $urandom_range(1024, 12000));
        end
      endcase
      random_items(55);
      drain();
    end

    // Receiver held off while the sender keeps offering, with zero lookahead.
    in_idle_pct = 0;
    out_idle_pct = 0;
    write_reg(CFG_LA_MIN, 32'h0);
    write_reg(CFG_LA_MAX, 32'h0);
    write_reg(CFG_LA_GAIN, 32'h0);
    rx_hold = 4000;
    random_items(30);
    drain();

    if (errors == 0 && expected_steer.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

### sim.f
hdl/pps_pkg.sv
hdl/pps_ram.sv
hdl/pps_steer.sv
hdl/pure_pursuit_steering.sv
tb/sv/testbench.sv
